// File: rtl/car_pkg.sv
// ----------------------------------------------------------------------------
// car_pkg: shared sizes, types and codes
// Table geometry, arithmetic widths and the controller/datapath interface
// structs for the contingency table residual block.
// ----------------------------------------------------------------------------
package car_pkg;

  // Table geometry
  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;

  // Input field widths
  localparam int ROW_IN_W = 4;
  localparam int COL_IN_W = 4;
  localparam int CNT_IN_W = 16;
  localparam int RES_W    = 32;

  // Index and storage widths
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int RT_W    = CNT_IN_W + $clog2(MAX_COLS);
  localparam int CT_W    = CNT_IN_W + $clog2(MAX_ROWS);
  localparam int GT_W    = CNT_IN_W + CELL_AW;

  // Arithmetic widths
  localparam int P_W  = CNT_IN_W + GT_W;            // n * N
  localparam int Q_W  = RT_W + CT_W;                // r * c
  localparam int A_W  = (P_W > Q_W) ? P_W : Q_W;    // |nN - rc|
  localparam int M1_W = 2 * A_W;                    // a^2
  localparam int L_W  = M1_W + GT_W;                // a^2 * N
  localparam int T_W  = 2 * GT_W;                   // (N-r)(N-c)
  localparam int D_W  = Q_W + T_W;                  // r c (N-r)(N-c)

  // Shared multiplier: multiplicand by 16-bit digits of the multiplier
  localparam int MA_W    = M1_W;
  localparam int MB_W    = T_W;
  localparam int PR_W    = MA_W + MB_W;
  localparam int MUL_DIG = (MB_W + 15) / 16;
  localparam int DIG_W   = $clog2(MUL_DIG);

  // Divider and square root
  localparam int FRAC_W    = 32;
  localparam int SH_W      = 2 * FRAC_W;
  localparam int SQ_W      = 2 * FRAC_W;
  localparam int DIV_STEPS = SH_W;
  localparam int SQ_STEPS  = SQ_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int LSH_W     = L_W - FRAC_W;
  localparam int CMP_W     = (LSH_W > D_W) ? LSH_W : D_W;

  // Multiplier operations, in issue order
  typedef enum logic [2:0] {
    OP_P  = 3'd0,
    OP_Q  = 3'd1,
    OP_AA = 3'd2,
    OP_L  = 3'd3,
    OP_T  = 3'd4,
    OP_D  = 3'd5
  } mul_op_t;

  typedef struct packed {
    logic             accept;
    logic             load;
    logic             mul_start;
    logic             mul_step;
    logic             mul_store;
    mul_op_t          op;
    logic [DIG_W-1:0] dig;
    logic             div_init;
    logic             div_step;
    logic             sq_step;
    logic             fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic undef;
    logic ovf;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: rtl/car_ram.sv
// ----------------------------------------------------------------------------
// car_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module car_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/car_ctrl.sv
// ----------------------------------------------------------------------------
// car_ctrl: sequencing controller
// Walks one item through read, check, the multiply chain, the divider and
// the square root, and hands the result to the output register.
// ----------------------------------------------------------------------------
module car_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  car_pkg::ctrl_sts_t  sts,
  output car_pkg::ctrl_cmd_t  cmd
);
  import car_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_READ   = 10'b0000000010,
    S_CHECK  = 10'b0000000100,
    S_MSTART = 10'b0000001000,
    S_MRUN   = 10'b0000010000,
    S_MSTORE = 10'b0000100000,
    S_DIVCHK = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_SQRT   = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

  state_t           state_r, state_nxt;
  mul_op_t          op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = op_r;
    cmd.dig   = cnt_r[DIG_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.load  = 1'b1;
        state_nxt = sts.is_write ? S_FIN : S_CHECK;
      end
      S_CHECK: begin
        op_nxt    = OP_P;
        state_nxt = sts.undef ? S_FIN : S_MSTART;
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_MRUN;
      end
      S_MRUN: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_DIG - 1)) begin
          state_nxt = S_MSTORE;
        end
      end
      S_MSTORE: begin
        cmd.mul_store = 1'b1;
        if (op_r == OP_D) begin
          state_nxt = S_DIVCHK;
        end else begin
          state_nxt = S_MSTART;
          unique case (op_r)
            OP_P:    op_nxt = OP_Q;
            OP_Q:    op_nxt = OP_AA;
            OP_AA:   op_nxt = OP_L;
            OP_L:    op_nxt = OP_T;
            OP_T:    op_nxt = OP_D;
            default: op_nxt = OP_P;
          endcase
        end
      end
      S_DIVCHK: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = sts.ovf ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_P;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/car_dp.sv
// ----------------------------------------------------------------------------
// car_dp: table storage and residual datapath
// Holds the cell RAM and the running totals, and computes the residual with
// a digit-serial multiplier, a restoring divider and a bit-pair square root.
// ----------------------------------------------------------------------------
module car_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [23:0]        in_tdata,
  input  logic               in_tuser,
  input  car_pkg::ctrl_cmd_t cmd,
  output car_pkg::ctrl_sts_t sts,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  output logic               out_tuser
);
  import car_pkg::*;

  // Input fields
  logic [ROW_IN_W-1:0] in_row;
  logic [COL_IN_W-1:0] in_col;
  logic [CNT_IN_W-1:0] in_cnt;
  logic [CELL_AW-1:0]  in_addr;
  logic                in_inside;

  assign in_row    = in_tdata[3:0];
  assign in_col    = in_tdata[7:4];
  assign in_cnt    = in_tdata[23:8];
  assign in_addr   = CELL_AW'(CELL_AW'(in_row) * CELL_AW'(MAX_COLS)) + CELL_AW'(in_col);
  assign in_inside = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);

  // Captured item
  logic [ROW_IN_W-1:0] row_r;
  logic [COL_IN_W-1:0] col_r;
  logic [CNT_IN_W-1:0] cnt_r;
  logic [CELL_AW-1:0]  addr_r;
  logic                wr_r;
  logic                inside_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_r    <= in_row;
      col_r    <= in_col;
      cnt_r    <= in_cnt;
      addr_r   <= in_addr;
      wr_r     <= !in_tuser;
      inside_r <= in_inside;
    end
  end

  // Cell store
  logic [CNT_IN_W-1:0] ram_rdata;
  logic                commit;
  logic [CELLS-1:0]    vld_r;
  logic [CNT_IN_W-1:0] old;

  assign commit = cmd.load && wr_r && inside_r;
  assign old    = vld_r[addr_r] ? ram_rdata : '0;

  car_ram #(
    .WIDTH (CNT_IN_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (commit),
    .waddr (addr_r),
    .wdata (cnt_r),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Totals and valid bits
  logic [RT_W-1:0] rt_r [MAX_ROWS];
  logic [CT_W-1:0] ct_r [MAX_COLS];
  logic [GT_W-1:0] nt_r;
  logic [ROW_W-1:0] ri;
  logic [COL_W-1:0] ci;

  assign ri = ROW_W'(row_r);
  assign ci = COL_W'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      nt_r  <= '0;
      for (int i = 0; i < MAX_ROWS; i++) begin
        rt_r[i] <= '0;
      end
      for (int j = 0; j < MAX_COLS; j++) begin
        ct_r[j] <= '0;
      end
    end else if (commit) begin
      vld_r[addr_r] <= 1'b1;
      rt_r[ri]      <= rt_r[ri] - RT_W'(old) + RT_W'(cnt_r);
      ct_r[ci]      <= ct_r[ci] - CT_W'(old) + CT_W'(cnt_r);
      nt_r          <= nt_r - GT_W'(old) + GT_W'(cnt_r);
    end
  end

  // Query operands
  logic [CNT_IN_W-1:0] n_r;
  logic [RT_W-1:0]     rtq_r;
  logic [CT_W-1:0]     ctq_r;
  logic [GT_W-1:0]     ntq_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= old;
      rtq_r <= rt_r[ri];
      ctq_r <= ct_r[ci];
      ntq_r <= nt_r;
    end
  end

  // Zero denominator
  logic undef;
  assign undef = !inside_r || (rtq_r == '0) || (ctq_r == '0) ||
                 (GT_W'(rtq_r) >= ntq_r) || (GT_W'(ctq_r) >= ntq_r);

  // Products
  logic [P_W-1:0]  p_r;
  logic [Q_W-1:0]  q_r;
  logic [M1_W-1:0] m1_r;
  logic [L_W-1:0]  l_r;
  logic [T_W-1:0]  t_r;
  logic [D_W-1:0]  d_r;
  logic            neg;
  logic [A_W-1:0]  a;

  assign neg = A_W'(p_r) < A_W'(q_r);
  assign a   = neg ? (A_W'(q_r) - A_W'(p_r)) : (A_W'(p_r) - A_W'(q_r));

  // Digit-serial multiplier
  logic [MA_W-1:0]    ma_r;
  logic [MB_W-1:0]    mb_r;
  logic [PR_W-1:0]    prod_r;
  logic [MA_W+15:0]   pp;
  logic [PR_W-1:0]    pp_sh;

  assign pp    = ma_r * mb_r[15:0];
  assign pp_sh = PR_W'(pp) << {cmd.dig, 4'b0000};

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod_r <= '0;
      case (cmd.op)
        OP_P: begin
          ma_r <= MA_W'(n_r);
          mb_r <= MB_W'(ntq_r);
        end
        OP_Q: begin
          ma_r <= MA_W'(rtq_r);
          mb_r <= MB_W'(ctq_r);
        end
        OP_AA: begin
          ma_r <= MA_W'(a);
          mb_r <= MB_W'(a);
        end
        OP_L: begin
          ma_r <= MA_W'(m1_r);
          mb_r <= MB_W'(ntq_r);
        end
        OP_T: begin
          ma_r <= MA_W'(ntq_r - GT_W'(rtq_r));
          mb_r <= MB_W'(ntq_r - GT_W'(ctq_r));
        end
        default: begin
          ma_r <= MA_W'(q_r);
          mb_r <= MB_W'(t_r);
        end
      endcase
    end else if (cmd.mul_step) begin
      prod_r <= prod_r + pp_sh;
      mb_r   <= mb_r >> 16;
    end
  end

  // Write back the finished product
  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      case (cmd.op)
        OP_P:    p_r  <= prod_r[P_W-1:0];
        OP_Q:    q_r  <= prod_r[Q_W-1:0];
        OP_AA:   m1_r <= prod_r[M1_W-1:0];
        OP_L:    l_r  <= prod_r[L_W-1:0];
        OP_T:    t_r  <= prod_r[T_W-1:0];
        default: d_r  <= prod_r[D_W-1:0];
      endcase
    end
  end

  // Divider and square root
  logic [D_W-1:0]  rem_r;
  logic [SH_W-1:0] sh_r;
  logic [SQ_W-1:0] quo_r;
  logic [SQ_W-1:0] root_r;
  logic [SQ_W-1:0] one_r;
  logic            ovf_r;
  logic            ovf;
  logic [D_W:0]    rem_ext;
  logic [D_W:0]    rem_diff;
  logic            rem_ge;
  logic [SQ_W-1:0] sq_b;
  logic            sq_ge;

  assign ovf      = CMP_W'(l_r >> FRAC_W) >= CMP_W'(d_r);
  assign rem_ext  = {rem_r, sh_r[SH_W-1]};
  assign rem_ge   = rem_ext >= {1'b0, d_r};
  assign rem_diff = rem_ext - {1'b0, d_r};
  assign sq_b     = root_r + one_r;
  assign sq_ge    = quo_r >= sq_b;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      ovf_r  <= ovf;
      rem_r  <= D_W'(l_r >> FRAC_W);
      sh_r   <= {l_r[FRAC_W-1:0], FRAC_W'(0)};
      quo_r  <= '0;
      root_r <= '0;
      one_r  <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff[D_W-1:0] : rem_ext[D_W-1:0];
      sh_r  <= sh_r << 1;
      quo_r <= {quo_r[SQ_W-2:0], rem_ge};
    end else if (cmd.sq_step) begin
      if (sq_ge) begin
        quo_r  <= quo_r - sq_b;
        root_r <= (root_r >> 1) + one_r;
      end else begin
        root_r <= root_r >> 1;
      end
      one_r <= one_r >> 2;
    end
  end

  // Sign and saturation
  logic [RES_W-1:0] y;
  logic [RES_W-1:0] res;
  logic             und;

  always_comb begin
    y   = ovf_r ? '1 : root_r[RES_W-1:0];
    res = '0;
    und = 1'b0;
    if (wr_r) begin
      res = '0;
    end else if (undef) begin
      und = 1'b1;
    end else if (neg) begin
      res = (y > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - y);
    end else begin
      res = (y > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : y;
    end
  end

  // Output register
  logic             out_valid_r;
  logic [RES_W-1:0] out_res_r;
  logic             out_und_r;
  logic             out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && out_free) begin
      out_res_r <= res;
      out_und_r <= und;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;
  assign out_tuser  = out_und_r;

  // Status to the controller
  assign sts.is_write = wr_r;
  assign sts.undef    = undef;
  assign sts.ovf      = ovf;
  assign sts.out_free = out_free;

endmodule

// File: rtl/contingency_adjusted_residuals.sv
// ----------------------------------------------------------------------------
// contingency_adjusted_residuals: contingency table with adjusted residuals
// Keeps cell counts with row, column and grand totals; a write replaces a
// cell, a query returns (n-E)/sqrt(E(1-r/N)(1-c/N)) as saturated Q15.16.
//
//   channel  direction  tdata                                     tuser
//   in_      slave      row[3:0] col[7:4] cell_count[23:8]        mode
//   out_     master     residual[31:0]                            undefined
//
// A query runs 6 products through the shared 16-bit-digit multiplier, then
// 64 restoring divider steps and 32 square root steps; a query with a zero
// denominator skips all of them, and one whose root saturates skips the
// divider and square root. Reset clears every count and total at once. A
// result waits in the output register; the next item is taken meanwhile and
// stalls only at its own result.
// ----------------------------------------------------------------------------
module contingency_adjusted_residuals (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row[3:0], col[7:4], cell_count[23:8]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // residual[31:0]
  output logic        out_tuser   // undefined
);
  import car_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  car_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  car_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
